// File: hw/rtl/imu_spd_pkg.sv
// Shared types and constants for the IMU serial packet decoder.
`default_nettype none

package imu_spd_pkg;

    // Framing bytes
    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] TYPE_FIRST  = 8'h51;
    localparam logic [7:0] TYPE_LAST   = 8'h54;

    // Byte positions inside a packet
    localparam logic [3:0] POS_HUNT     = 4'd0;
    localparam logic [3:0] POS_TYPE     = 4'd1;
    localparam logic [3:0] POS_PAYLOAD  = 4'd2;
    localparam logic [3:0] POS_CHECKSUM = 4'd10;

    localparam int NumWords = 4;

    // Acceleration: floor(raw*1568/5). Offset keeps the dividend positive,
    // reciprocal of 5 scaled by 2^30 is exact for dividends below 2^30.
    localparam logic [10:0] ACC_MULT   = 11'd1568;
    localparam logic [27:0] ACC_OFFSET = 28'd83886080;   // 5 * 2^24
    localparam logic [27:0] ACC_RECIP  = 28'd214748365;  // ceil(2^30 / 5)
    localparam int          AccShift   = 30;
    localparam logic [31:0] ACC_BIAS   = 32'd16777216;   // 2^24

    // Temperature: floor(raw*16384/25), reciprocal of 25 scaled by 2^35.
    localparam logic [30:0] TEMP_OFFSET = 31'd838860800;   // 25 * 2^25
    localparam logic [30:0] TEMP_RECIP  = 31'd1374389535;  // ceil(2^35 / 25)
    localparam int          TempShift   = 35;
    localparam logic [26:0] TEMP_BIAS   = 27'd33554432;    // 2^25

    // Other axis scale factors
    localparam logic [11:0] GYRO_MULT  = 12'd4000;
    localparam logic [8:0]  ANGLE_MULT = 9'd360;

    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_GYRO  = 2'd1,
        KIND_ANGLE = 2'd2,
        KIND_MAG   = 2'd3
    } t_kind;

    // One framed, checked packet handed from parser to scaler
    typedef struct packed {
        t_kind                     kind;
        logic [NumWords-1:0][15:0] words;
    } t_packet;

endpackage : imu_spd_pkg

`default_nettype wire

// File: hw/rtl/imu_serial_packet_decoder_top.sv
// Top level of the IMU serial packet decoder: ports, enable register, wiring.
//
// Input stream: one received serial byte per transfer on s_axis_tdata.
// Output stream: one reading per good packet (header 0x55, type 0x51..0x54,
// four little-endian 16-bit words, 8-bit sum checksum). m_axis_tuser holds
// the reading kind, m_axis_tdata the three axes in Q16.16 and temperature in Q10.16.
// Packets with a bad checksum or unknown type are consumed and dropped.
// Configuration: i_cfg_we writes i_cfg_wdata into the enable bit; while it
// is low, bytes are still taken but ignored and framing state holds.
// Throughput: one byte per cycle while s_axis_tready is high. The parser register
// loads at the transfer of the checksum byte, then the scale register and then
// the output register, which drives m_axis_tvalid.
// Reset clears the framing counter, checksum, all valid flags and sets
// enable to one. A stalled receiver holds the reading on the output; the
// two internal registers keep absorbing bytes until three readings are
// queued, then s_axis_tready drops.
`default_nettype none

module imu_serial_packet_decoder_top (
    input  wire           i_clk,
    input  wire           i_rst_n,
    // Configuration
    input  wire           i_cfg_we,
    input  wire           i_cfg_wdata,     // enable
    // Byte stream in
    input  wire           s_axis_tvalid,
    output logic          s_axis_tready,
    input  wire  [7:0]    s_axis_tdata,    // rx_byte
    // Reading stream out
    output logic          m_axis_tvalid,
    input  wire           m_axis_tready,
    output logic [127:0]  m_axis_tdata,    // axis_x, axis_y, axis_z, temperature, zero pad
    output logic [1:0]    m_axis_tuser     // kind
);
    import imu_spd_pkg::*;

    logic        r_enable;
    logic        byte_take;
    logic        pkt_valid;
    logic        pkt_ready;
    t_packet     pkt;
    t_kind       out_kind;
    logic [31:0] out_axis [3];
    logic [25:0] out_temp;

    // Enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_wdata;
        end
    end

    assign byte_take = s_axis_tvalid && s_axis_tready;

    imu_spd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_enable     (r_enable),
        .i_byte_valid (byte_take),
        .i_byte       (s_axis_tdata),
        .o_ready      (s_axis_tready),
        .o_pkt_valid  (pkt_valid),
        .o_pkt        (pkt),
        .i_pkt_ready  (pkt_ready)
    );

    imu_spd_scaler u_scaler (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pkt_valid  (pkt_valid),
        .i_pkt        (pkt),
        .o_pkt_ready  (pkt_ready),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_kind       (out_kind),
        .o_axis       (out_axis),
        .o_temp       (out_temp)
    );

    // Output packing, first field in the lowest bits
    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = {6'd0, out_temp, out_axis[2], out_axis[1], out_axis[0]};

endmodule : imu_serial_packet_decoder_top

`default_nettype wire

// File: hw/rtl/imu_spd_parser.sv
// Byte framing, checksum and type check for 11-byte IMU packets.
`default_nettype none

module imu_spd_parser (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_enable,
    input  wire                  i_byte_valid,   // byte transfer this cycle
    input  wire  [7:0]           i_byte,
    output logic                 o_ready,
    output logic                 o_pkt_valid,
    output imu_spd_pkg::t_packet o_pkt,
    input  wire                  i_pkt_ready
);
    import imu_spd_pkg::*;

    logic [3:0]      r_pos, n_pos;
    logic [7:0]      r_sum, n_sum;
    logic [7:0]      r_type;
    logic [7:0]      r_payload [8];
    logic            r_pkt_valid, n_pkt_valid;
    t_packet         r_pkt, n_pkt;
    logic            take;
    logic            type_ok;
    logic [2:0]      wr_idx;

    assign o_ready     = !r_pkt_valid || i_pkt_ready;
    assign take        = i_byte_valid && i_enable;
    assign type_ok     = (r_type >= TYPE_FIRST) && (r_type <= TYPE_LAST);
    assign wr_idx      = 3'(r_pos - POS_PAYLOAD);
    assign o_pkt_valid = r_pkt_valid;
    assign o_pkt       = r_pkt;

    // Framing counter, running sum and packet handoff
    always_comb begin
        n_pos       = r_pos;
        n_sum       = r_sum;
        n_pkt_valid = r_pkt_valid && !i_pkt_ready;
        n_pkt       = r_pkt;
        if (take) begin
            if (r_pos == POS_HUNT) begin
                if (i_byte == HEADER_BYTE) begin
                    n_sum = i_byte;
                    n_pos = POS_TYPE;
                end
            end else if (r_pos < POS_CHECKSUM) begin
                n_sum = 8'(r_sum + i_byte);
                n_pos = 4'(r_pos + 4'd1);
            end else begin
                n_pos = POS_HUNT;
                if ((i_byte == r_sum) && type_ok) begin
                    n_pkt_valid = 1'b1;
                    n_pkt.kind  = t_kind'(2'(r_type - TYPE_FIRST));
                    for (int w = 0; w < NumWords; w++) begin
                        n_pkt.words[w] = {r_payload[2*w+1], r_payload[2*w]};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_HUNT;
            r_sum       <= '0;
            r_pkt_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_pkt_valid <= n_pkt_valid;
        end
    end

    // Packet contents: no reset, always written before read
    always_ff @(posedge i_clk) begin
        r_pkt <= n_pkt;
        if (take && r_pos == POS_TYPE) begin
            r_type <= i_byte;
        end
        if (take && r_pos >= POS_PAYLOAD && r_pos < POS_CHECKSUM) begin
            r_payload[wr_idx] <= i_byte;
        end
    end

    // Counter never leaves the packet length
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_CHECKSUM)
        else $error("parser position out of range");

    // Checksum byte always ends the packet
    a_pos_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_pos == POS_CHECKSUM) |=> (r_pos == POS_HUNT))
        else $error("packet did not end after checksum byte");

    // A new packet appears only right after a checksum byte
    a_pkt_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pkt_valid) |-> $past(take && r_pos == POS_CHECKSUM))
        else $error("packet raised without checksum byte");

endmodule : imu_spd_parser

`default_nettype wire

// File: hw/rtl/imu_spd_scaler.sv
// Two-stage fixed-point scaling of packet words into Q16.16 axis and Q10.16 temperature readings.
`default_nettype none

module imu_spd_scaler (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_pkt_valid,
    input  wire imu_spd_pkg::t_packet i_pkt,
    output logic                 o_pkt_ready,
    output logic                 o_valid,
    input  wire                  i_ready,
    output imu_spd_pkg::t_kind   o_kind,
    output logic [31:0]          o_axis [3],
    output logic [25:0]          o_temp
);
    import imu_spd_pkg::*;

    // Stage 1: scaled axes, or offset dividends for acceleration
    logic               r_pre_valid;
    t_kind              r_pre_kind;
    logic [31:0]        r_pre [3];
    logic [30:0]        r_pre_temp;
    logic               pre_ready;

    // Stage 2: output register
    logic               r_out_valid;
    t_kind              r_out_kind;
    logic [31:0]        r_out [3];
    logic [25:0]        r_out_temp;
    logic               out_ready;

    logic [31:0]        n_pre [3];
    logic [30:0]        n_pre_temp;
    logic [31:0]        n_out [3];
    logic [25:0]        n_out_temp;
    logic signed [15:0] temp_raw;
    logic [61:0]        temp_prod;
    logic [26:0]        temp_q;

    assign out_ready   = !r_out_valid || i_ready;
    assign pre_ready   = !r_pre_valid || out_ready;
    assign o_pkt_ready = pre_ready;

    // First stage: constant multiplies by shift and add
    always_comb begin
        logic signed [15:0] raw;
        logic signed [27:0] acc_prod;
        for (int i = 0; i < 3; i++) begin
            raw      = $signed(i_pkt.words[i]);
            acc_prod = 28'(raw) * $signed({17'd0, ACC_MULT});
            unique case (i_pkt.kind)
                KIND_ACCEL: n_pre[i] = {4'd0, 28'(acc_prod + $signed(ACC_OFFSET))};
                KIND_GYRO:  n_pre[i] = 32'(32'(raw) * $signed({20'd0, GYRO_MULT}));
                KIND_ANGLE: n_pre[i] = 32'(32'(raw) * $signed({23'd0, ANGLE_MULT}));
                KIND_MAG:   n_pre[i] = {i_pkt.words[i], 16'd0};
                default:    n_pre[i] = '0;
            endcase
        end
    end

    // Sign-extended raw*16384 plus offset keeps the dividend positive
    assign temp_raw   = $signed(i_pkt.words[3]);
    assign n_pre_temp = {temp_raw[15], temp_raw, 14'd0} + TEMP_OFFSET;

    // Second stage: reciprocal multiplies for the floored divisions
    always_comb begin
        logic [55:0] acc_p;
        logic [25:0] acc_q;
        for (int i = 0; i < 3; i++) begin
            acc_p = 56'(r_pre[i][27:0]) * 56'(ACC_RECIP);
            acc_q = acc_p[55:AccShift];
            if (r_pre_kind == KIND_ACCEL) begin
                n_out[i] = 32'({6'd0, acc_q}) - ACC_BIAS;
            end else begin
                n_out[i] = r_pre[i];
            end
        end
    end

    assign temp_prod  = 62'(r_pre_temp) * 62'(TEMP_RECIP);
    assign temp_q     = temp_prod[61:TempShift];
    assign n_out_temp = 26'(temp_q - TEMP_BIAS);

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pre_ready) begin
                r_pre_valid <= i_pkt_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_pre_valid;
            end
        end
    end

    // Data registers
    always_ff @(posedge i_clk) begin
        if (pre_ready) begin
            r_pre_kind <= i_pkt.kind;
            r_pre      <= n_pre;
            r_pre_temp <= n_pre_temp;
        end
        if (out_ready) begin
            r_out_kind <= r_pre_kind;
            r_out      <= n_out;
            r_out_temp <= n_out_temp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_axis  = r_out;
    assign o_temp  = r_out_temp;

endmodule : imu_spd_scaler

`default_nettype wire

// File: tb/tb_imu_serial_packet_decoder_top.sv
// Self-checking testbench for the IMU serial packet decoder: byte stream in, scaled readings out.
module tb_imu_serial_packet_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import imu_spd_pkg::*;

    localparam int DRAIN_CYCLES = 12;      // output pipe is three stages deep
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 40;
    localparam int HOLD_AFTER   = 400;     // bytes taken before the long receiver hold-off
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] axis_x;
        logic [31:0] axis_y;
        logic [31:0] axis_z;
        logic [25:0] temperature;
    } t_reading;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         i_cfg_we      = 1'b0;
    logic         i_cfg_wdata   = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = 8'h00;    // rx_byte
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;             // axis_x, axis_y, axis_z, temperature, zero pad
    logic [1:0]   m_axis_tuser;             // kind

    // Byte source and expected readings
    logic [7:0]   pending_bytes[$];
    t_reading     readings_due[$];
    t_reading     head_reading;
    logic         byte_accepted = 1'b0;
    int           bytes_taken   = 0;
    int           mismatch_count = 0;
    int           cycle_count   = 0;

    // Shadow of the decoder state
    logic         en_shadow = 1'b1;
    logic [3:0]   frame_pos = POS_HUNT;
    logic [7:0]   frame_sum = 8'h00;
    logic [7:0]   frame_type = 8'h00;
    logic [7:0]   frame_payload[8];

    // Sender burst and receiver stall state
    int           burst_left = 20;
    int           gap_left   = 0;
    int           ready_mode = 0;
    int           mode_left  = 0;
    int           hold_left  = 0;
    bit           hold_done  = 1'b0;

    imu_serial_packet_decoder_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Division rounding toward minus infinity
    function automatic longint floor_div(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        return q;
    endfunction

    function automatic logic [31:0] scale_axis(input t_kind kind, input logic [15:0] raw);
        longint r;
        longint v;
        r = longint'($signed(raw));
        case (kind)
            KIND_ACCEL: v = floor_div(r * 1568, 5);
            KIND_GYRO:  v = r * 4000;
            KIND_ANGLE: v = r * 360;
            default:    v = r * 65536;
        endcase
        return v[31:0];
    endfunction

    function automatic logic [25:0] scale_temperature(input logic [15:0] raw);
        longint v;
        v = floor_div(longint'($signed(raw)) * 16384, 25);
        return v[25:0];
    endfunction

    // Advance the shadow parser by one accepted byte; queue a reading on a good packet
    task automatic decode_byte(input logic [7:0] b);
        t_reading   rd;
        logic [7:0] kind_byte;
        if (!en_shadow) return;
        if (frame_pos == POS_HUNT) begin
            if (b == HEADER_BYTE) begin
                frame_sum = b;
                frame_pos = POS_TYPE;
            end
        end else if (frame_pos != POS_CHECKSUM) begin
            if (frame_pos == POS_TYPE) frame_type = b;
            else frame_payload[3'(frame_pos - POS_PAYLOAD)] = b;
            frame_sum = frame_sum + b;
            frame_pos = frame_pos + 4'd1;
        end else begin
            frame_pos = POS_HUNT;
            if (b == frame_sum && frame_type >= TYPE_FIRST && frame_type <= TYPE_LAST) begin
                kind_byte      = frame_type - TYPE_FIRST;
                rd.kind        = t_kind'(kind_byte[1:0]);
                rd.axis_x      = scale_axis(rd.kind, {frame_payload[1], frame_payload[0]});
                rd.axis_y      = scale_axis(rd.kind, {frame_payload[3], frame_payload[2]});
                rd.axis_z      = scale_axis(rd.kind, {frame_payload[5], frame_payload[4]});
                rd.temperature = scale_temperature({frame_payload[7], frame_payload[6]});
                readings_due.push_back(rd);
            end
        end
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        end
    endtask

    // Monitor: track accepted bytes and config writes, check each reading transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_accepted <= 1'b0;
            en_shadow = 1'b1;
            frame_pos = POS_HUNT;
            frame_sum = 8'h00;
        end else begin
            byte_accepted <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                bytes_taken++;
                decode_byte(s_axis_tdata);
            end
            if (i_cfg_we) en_shadow = i_cfg_wdata;
            if (m_axis_tvalid && m_axis_tready) begin
                if (readings_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected reading, expected none, got kind %0d data %h",
                                 $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    head_reading = readings_due.pop_front();
                    compare_field("kind", 32'(head_reading.kind), 32'(m_axis_tuser));
                    compare_field("axis_x", head_reading.axis_x, m_axis_tdata[31:0]);
                    compare_field("axis_y", head_reading.axis_y, m_axis_tdata[63:32]);
                    compare_field("axis_z", head_reading.axis_z, m_axis_tdata[95:64]);
                    compare_field("temperature", 32'(head_reading.temperature),
                                  32'(m_axis_tdata[121:96]));
                end
            end
        end
    end

    // Sender: bursts of random length with random gaps, valid held until transfer
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || byte_accepted) begin
            if (s_axis_tvalid) pending_bytes.delete(0);
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_bytes[0];
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: switches between always ready, coin flip and mostly stalled;
    // one long hold-off lets the decoder fill up and push back on the input
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && bytes_taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(10, 80);
            end else begin
                mode_left--;
            end
            case (ready_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= $urandom_range(0, 1);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Queue bytes [from_byte, to_byte) of a packet; sum_error != 0 corrupts the checksum
    task automatic add_packet(input logic [7:0] ptype, input logic [63:0] words,
                              input logic [7:0] sum_error, input int from_byte,
                              input int to_byte);
        logic [7:0] frame[11];
        logic [7:0] sum;
        frame[0] = HEADER_BYTE;
        frame[1] = ptype;
        for (int i = 0; i < 8; i++) frame[2 + i] = words[8 * i +: 8];
        sum = 8'h00;
        for (int i = 0; i < 10; i++) sum = sum + frame[i];
        frame[10] = sum + sum_error;
        for (int i = from_byte; i < to_byte; i++) pending_bytes.push_back(frame[i]);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] pick_words();
        return {pick_word(), pick_word(), pick_word(), pick_word()};
    endfunction

    // Mostly good packets, plus unknown types, bad checksums, stray and cut-off bytes
    task automatic add_random_traffic(input int n_bytes);
        int         start;
        int         pick;
        logic [7:0] ptype;
        start = pending_bytes.size();
        while (pending_bytes.size() - start < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                add_packet(8'($urandom_range(TYPE_FIRST, TYPE_LAST)), pick_words(), 8'h00, 0, 11);
            end else if (pick < 83) begin
                ptype = 8'($urandom);
                if (ptype >= TYPE_FIRST && ptype <= TYPE_LAST) ptype = ptype ^ 8'h08;
                add_packet(ptype, pick_words(), 8'h00, 0, 11);
            end else if (pick < 91) begin
                add_packet(8'($urandom_range(TYPE_FIRST, TYPE_LAST)), pick_words(),
                           8'($urandom_range(1, 255)), 0, 11);
            end else if (pick < 96) begin
                repeat ($urandom_range(1, 5)) pending_bytes.push_back(8'($urandom));
            end else begin
                add_packet(8'($urandom_range(TYPE_FIRST, TYPE_LAST)), pick_words(), 8'h00,
                           0, $urandom_range(2, 10));
            end
        end
    endtask

    // Wait until every byte is taken and every reading checked, then let the pipe drain
    task automatic settle();
        while (pending_bytes.size() != 0 || s_axis_tvalid || readings_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Stimulus sequence
    initial begin
        logic [63:0] split_words;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        write_enable(1'b1);

        // Directed: stray bytes, each kind at word extremes, header byte inside payload,
        // bad checksum, unknown types
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'hAA);
        add_packet(8'h51, 64'h0001_FFFF_7FFF_8000, 8'h00, 0, 11);
        add_packet(8'h52, 64'h8000_0000_8000_7FFF, 8'h00, 0, 11);
        add_packet(8'h53, 64'h7FFF_7FFF_0001_FFFF, 8'h00, 0, 11);
        add_packet(8'h54, 64'hFFFF_1234_7FFF_8000, 8'h00, 0, 11);
        add_packet(8'h51, 64'h5555_0055_5500_FFFB, 8'h00, 0, 11);
        add_packet(8'h52, 64'h1111_2222_3333_4444, 8'h01, 0, 11);
        add_packet(8'h50, 64'h0102_0304_0506_0708, 8'h00, 0, 11);
        add_packet(8'h55, 64'h8000_8000_8000_8000, 8'h00, 0, 11);
        add_packet(8'h54, 64'h0000_0000_0000_0000, 8'h00, 0, 11);
        settle();

        // Disabled: bytes are taken but have no effect
        write_enable(1'b0);
        add_random_traffic(40);
        settle();

        write_enable(1'b1);
        add_random_traffic(400);
        // Leave a packet half done across a disabled stretch
        split_words = pick_words();
        add_packet(8'h53, split_words, 8'h00, 0, 6);
        settle();

        write_enable(1'b0);
        add_random_traffic(30);
        settle();

        write_enable(1'b1);
        add_packet(8'h53, split_words, 8'h00, 6, 11);
        add_random_traffic(350);
        settle();

        write_enable(1'b0);
        add_random_traffic(30);
        settle();

        write_enable(1'b1);
        add_random_traffic(300);
        settle();

        if (mismatch_count == 0 && readings_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
